[sv/typed_priority_job_dispatcher_defines.svh]
// Assertion macros for the typed priority job dispatcher
`ifndef TYPED_PRIORITY_JOB_DISPATCHER_DEFINES_SVH
`define TYPED_PRIORITY_JOB_DISPATCHER_DEFINES_SVH

// same-cycle implication
`define TPJD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dispatcher check failed");

// delayed implication, consequence checked after the antecedent
`define TPJD_ASSERT_D2(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("dispatcher check failed");

`endif

[sv/tpjd_pkg.sv]
// Package: shared types, codes and constants of the job dispatcher
`timescale 1ns / 1ps
`default_nettype none
package tpjd_pkg;
	localparam int WORKERS_DEF = 8;
	localparam int HIGH_DEPTH_DEF = 128;
	localparam int MEDIUM_DEPTH_DEF = 512;
	localparam int LOW_DEPTH_DEF = 128;
	localparam int TYPE_BITS = 3;
	localparam int TAG_BITS = 16;
	localparam int MASKS_BITS = 24;
	localparam int COUNT_BITS = 4;

	typedef enum logic [1:0] {
		FUNC_SUBMIT = 2'd0,
		FUNC_UPDATE = 2'd1,
		FUNC_DONE   = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		PRIO_LOW  = 2'd0,
		PRIO_MED  = 2'd1,
		PRIO_HIGH = 2'd2,
		PRIO_ALT  = 2'd3
	} prio_t;

	typedef enum logic [2:0] {
		EV_ASSIGNED = 3'd0,
		EV_QUEUED   = 3'd1,
		EV_DROPPED  = 3'd2,
		EV_UPD_DONE = 3'd3,
		EV_RELEASED = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		SRC_DIRECT = 2'd0,
		SRC_HIGH   = 2'd1,
		SRC_MEDIUM = 2'd2,
		SRC_LOW    = 2'd3
	} src_t;

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_COUNT  = 2'd1,
		REG_MASKS  = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_REL,
		ST_RD,
		ST_CHK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic sub;
		logic rel;
		logic pop;
		logic next_q;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic enable;
		logic empty;
		logic found;
		logic last_q;
	} sts_t;
endpackage
`default_nettype wire

[sv/tpjd_ctrl.sv]
// Controller: sequences submit, release and queue drain passes
`timescale 1ns / 1ps
`default_nettype none
module tpjd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [1:0]    func,
	input  tpjd_pkg::sts_t     sts,
	output tpjd_pkg::cmd_t     cmd,
	output logic               busy
);
	tpjd_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpjd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		unique case (state_q)
			tpjd_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (tpjd_pkg::func_t'(func))
						tpjd_pkg::FUNC_SUBMIT: state_nxt = tpjd_pkg::ST_SUB;
						tpjd_pkg::FUNC_UPDATE:
							state_nxt = sts.enable ? tpjd_pkg::ST_RD : tpjd_pkg::ST_FIN;
						tpjd_pkg::FUNC_DONE: state_nxt = tpjd_pkg::ST_REL;
						default: state_nxt = tpjd_pkg::ST_IDLE;
					endcase
				end
			end
			tpjd_pkg::ST_SUB: begin
				cmd.sub = 1'b1;
				state_nxt = tpjd_pkg::ST_IDLE;
			end
			tpjd_pkg::ST_REL: begin
				cmd.rel = 1'b1;
				state_nxt = tpjd_pkg::ST_IDLE;
			end
			tpjd_pkg::ST_RD: begin
				if (sts.empty) begin
					cmd.next_q = 1'b1;
					state_nxt = sts.last_q ? tpjd_pkg::ST_FIN : tpjd_pkg::ST_RD;
				end else begin
					state_nxt = tpjd_pkg::ST_CHK;
				end
			end
			tpjd_pkg::ST_CHK: begin
				if (sts.found) begin
					cmd.pop = 1'b1;
					state_nxt = tpjd_pkg::ST_RD;
				end else begin
					cmd.next_q = 1'b1;
					state_nxt = sts.last_q ? tpjd_pkg::ST_FIN : tpjd_pkg::ST_RD;
				end
			end
			tpjd_pkg::ST_FIN: begin
				cmd.fin = 1'b1;
				state_nxt = tpjd_pkg::ST_IDLE;
			end
			default: state_nxt = tpjd_pkg::ST_IDLE;
		endcase
	end

	assign busy = (state_q != tpjd_pkg::ST_IDLE);
endmodule
`default_nettype wire

[sv/tpjd_datapath.sv]
// Datapath: config registers, worker state, queue memories, result register
`timescale 1ns / 1ps
`default_nettype none
module tpjd_datapath #(
	parameter int WORKERS      = tpjd_pkg::WORKERS_DEF,
	parameter int HIGH_DEPTH   = tpjd_pkg::HIGH_DEPTH_DEF,
	parameter int MEDIUM_DEPTH = tpjd_pkg::MEDIUM_DEPTH_DEF,
	parameter int LOW_DEPTH    = tpjd_pkg::LOW_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [1:0]                     cfg_index,
	input  wire logic [tpjd_pkg::MASKS_BITS-1:0] cfg_data,
	input  wire logic [tpjd_pkg::TAG_BITS-1:0]  job_tag,
	input  wire logic [tpjd_pkg::TYPE_BITS-1:0] job_type_mask,
	input  wire logic [1:0]                     priority_req,
	input  wire logic [2:0]                     worker_id,
	input  tpjd_pkg::cmd_t                      cmd,
	output tpjd_pkg::sts_t                      sts,
	output logic                                strobe,
	output logic [2:0]                          event_kind,
	output logic [2:0]                          assigned_worker,
	output logic [tpjd_pkg::TAG_BITS-1:0]       out_tag,
	output logic [tpjd_pkg::TYPE_BITS-1:0]      out_type_mask,
	output logic [1:0]                          source_queue,
	output logic                                last_result
);
	localparam int TB = tpjd_pkg::TYPE_BITS;
	localparam int GB = tpjd_pkg::TAG_BITS;
	localparam int EW = GB + TB;
	localparam int WW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam int HA = $clog2(HIGH_DEPTH);
	localparam int MA = $clog2(MEDIUM_DEPTH);
	localparam int LA = $clog2(LOW_DEPTH);
	localparam int HF = $clog2(HIGH_DEPTH + 1);
	localparam int MF = $clog2(MEDIUM_DEPTH + 1);
	localparam int LF = $clog2(LOW_DEPTH + 1);

	// configuration
	logic                              en_q;
	logic [tpjd_pkg::COUNT_BITS-1:0]   cnt_q;
	logic [tpjd_pkg::MASKS_BITS-1:0]   masks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
			cnt_q <= tpjd_pkg::COUNT_BITS'(8);
			masks_q <= '1;
		end else if (cfg_valid) begin
			unique case (tpjd_pkg::reg_idx_t'(cfg_index))
				tpjd_pkg::REG_ENABLE: en_q <= cfg_data[0];
				tpjd_pkg::REG_COUNT:  cnt_q <= cfg_data[tpjd_pkg::COUNT_BITS-1:0];
				tpjd_pkg::REG_MASKS:  masks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// latched request
	logic [GB-1:0] tag_q;
	logic [TB-1:0] type_q;
	logic [1:0]    prio_q;
	logic [2:0]    wid_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tag_q <= job_tag;
			type_q <= job_type_mask;
			prio_q <= priority_req;
			wid_q <= worker_id;
		end
	end

	// current drain queue
	logic [1:0] q_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= tpjd_pkg::SRC_HIGH;
		end else if (cmd.load) begin
			q_q <= tpjd_pkg::SRC_HIGH;
		end else if (cmd.next_q) begin
			q_q <= q_q + 2'd1;
		end
	end

	// queue pointers and memories
	logic [HA-1:0] hh_q, ht_q;
	logic [MA-1:0] mh_q, mt_q;
	logic [LA-1:0] lh_q, lt_q;
	logic [HF-1:0] hf_q;
	logic [MF-1:0] mf_q;
	logic [LF-1:0] lf_q;
	logic [EW-1:0] mem_h [HIGH_DEPTH];
	logic [EW-1:0] mem_m [MEDIUM_DEPTH];
	logic [EW-1:0] mem_l [LOW_DEPTH];
	logic [EW-1:0] rd_h_q, rd_m_q, rd_l_q;

	logic full_h, full_m, full_l;
	assign full_h = (hf_q == HF'(HIGH_DEPTH));
	assign full_m = (mf_q == MF'(MEDIUM_DEPTH));
	assign full_l = (lf_q == LF'(LOW_DEPTH));

	// worker match
	logic [TB-1:0] wmask [WORKERS];
	logic [WORKERS-1:0] busy_q, act, match_sub, match_head;
	logic [EW-1:0] head_e;
	logic [GB-1:0] head_tag;
	logic [TB-1:0] head_type;

	always_comb begin
		unique case (tpjd_pkg::src_t'(q_q))
			tpjd_pkg::SRC_HIGH:   head_e = rd_h_q;
			tpjd_pkg::SRC_MEDIUM: head_e = rd_m_q;
			default:              head_e = rd_l_q;
		endcase
	end
	assign head_tag = head_e[GB-1:0];
	assign head_type = head_e[EW-1:GB];

	for (genvar w = 0; w < WORKERS; w++) begin : g_w
		if ((w + 1) * TB <= tpjd_pkg::MASKS_BITS) begin : g_in
			assign wmask[w] = masks_q[w*TB +: TB];
		end else begin : g_out
			assign wmask[w] = '0;
		end
		assign act[w] = (6'(cnt_q) > 6'(w));
		assign match_sub[w] = (|(wmask[w] & type_q)) & ~busy_q[w] & act[w];
		assign match_head[w] = (|(wmask[w] & head_type)) & ~busy_q[w] & act[w];
	end

	logic found_sub, found_head;
	logic [WW-1:0] idx_sub, idx_head;
	always_comb begin
		found_sub = 1'b0;
		found_head = 1'b0;
		idx_sub = '0;
		idx_head = '0;
		for (int i = WORKERS - 1; i >= 0; i--) begin
			if (match_sub[i]) begin
				found_sub = 1'b1;
				idx_sub = WW'(i);
			end
			if (match_head[i]) begin
				found_head = 1'b1;
				idx_head = WW'(i);
			end
		end
	end

	// submit decision
	logic direct, sel_full, enq;
	logic [1:0] sel_q;
	always_comb begin
		direct = (prio_q == tpjd_pkg::PRIO_HIGH) && found_sub;
		if (prio_q == tpjd_pkg::PRIO_HIGH) begin
			sel_q = tpjd_pkg::SRC_HIGH;
		end else if (prio_q == tpjd_pkg::PRIO_LOW) begin
			sel_q = tpjd_pkg::SRC_LOW;
		end else begin
			sel_q = tpjd_pkg::SRC_MEDIUM;
		end
		unique case (tpjd_pkg::src_t'(sel_q))
			tpjd_pkg::SRC_HIGH:   sel_full = full_h;
			tpjd_pkg::SRC_MEDIUM: sel_full = full_m;
			default:              sel_full = full_l;
		endcase
		enq = cmd.sub && !direct && !sel_full;
	end

	logic we_h, we_m, we_l, pop_h, pop_m, pop_l;
	assign we_h = enq && (sel_q == tpjd_pkg::SRC_HIGH);
	assign we_m = enq && (sel_q == tpjd_pkg::SRC_MEDIUM);
	assign we_l = enq && (sel_q == tpjd_pkg::SRC_LOW);
	assign pop_h = cmd.pop && (q_q == tpjd_pkg::SRC_HIGH);
	assign pop_m = cmd.pop && (q_q == tpjd_pkg::SRC_MEDIUM);
	assign pop_l = cmd.pop && (q_q == tpjd_pkg::SRC_LOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hh_q <= '0;
			ht_q <= '0;
			hf_q <= '0;
			mh_q <= '0;
			mt_q <= '0;
			mf_q <= '0;
			lh_q <= '0;
			lt_q <= '0;
			lf_q <= '0;
		end else begin
			if (we_h) begin
				ht_q <= (ht_q == HA'(HIGH_DEPTH - 1)) ? '0 : ht_q + HA'(1);
				hf_q <= hf_q + HF'(1);
			end
			if (pop_h) begin
				hh_q <= (hh_q == HA'(HIGH_DEPTH - 1)) ? '0 : hh_q + HA'(1);
				hf_q <= hf_q - HF'(1);
			end
			if (we_m) begin
				mt_q <= (mt_q == MA'(MEDIUM_DEPTH - 1)) ? '0 : mt_q + MA'(1);
				mf_q <= mf_q + MF'(1);
			end
			if (pop_m) begin
				mh_q <= (mh_q == MA'(MEDIUM_DEPTH - 1)) ? '0 : mh_q + MA'(1);
				mf_q <= mf_q - MF'(1);
			end
			if (we_l) begin
				lt_q <= (lt_q == LA'(LOW_DEPTH - 1)) ? '0 : lt_q + LA'(1);
				lf_q <= lf_q + LF'(1);
			end
			if (pop_l) begin
				lh_q <= (lh_q == LA'(LOW_DEPTH - 1)) ? '0 : lh_q + LA'(1);
				lf_q <= lf_q - LF'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we_h) begin
			mem_h[ht_q] <= {type_q, tag_q};
		end
		rd_h_q <= mem_h[hh_q];
	end

	always_ff @(posedge clk) begin
		if (we_m) begin
			mem_m[mt_q] <= {type_q, tag_q};
		end
		rd_m_q <= mem_m[mh_q];
	end

	always_ff @(posedge clk) begin
		if (we_l) begin
			mem_l[lt_q] <= {type_q, tag_q};
		end
		rd_l_q <= mem_l[lh_q];
	end

	// worker busy bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			for (int i = 0; i < WORKERS; i++) begin
				if ((cmd.sub && direct && idx_sub == WW'(i)) ||
				    (cmd.pop && idx_head == WW'(i))) begin
					busy_q[i] <= 1'b1;
				end else if (cmd.rel && 6'(wid_q) == 6'(i)) begin
					busy_q[i] <= 1'b0;
				end
			end
		end
	end

	// status
	always_comb begin
		sts.enable = en_q;
		sts.found = found_head;
		sts.last_q = (q_q == tpjd_pkg::SRC_LOW);
		unique case (tpjd_pkg::src_t'(q_q))
			tpjd_pkg::SRC_HIGH:   sts.empty = (hf_q == '0);
			tpjd_pkg::SRC_MEDIUM: sts.empty = (mf_q == '0);
			default:              sts.empty = (lf_q == '0);
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.sub | cmd.rel | cmd.pop | cmd.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sub) begin
			assigned_worker <= direct ? 3'(idx_sub) : 3'd0;
			out_tag <= tag_q;
			out_type_mask <= type_q;
			last_result <= 1'b1;
			if (direct) begin
				event_kind <= tpjd_pkg::EV_ASSIGNED;
				source_queue <= tpjd_pkg::SRC_DIRECT;
			end else begin
				event_kind <= sel_full ? tpjd_pkg::EV_DROPPED : tpjd_pkg::EV_QUEUED;
				source_queue <= sel_q;
			end
		end else if (cmd.pop) begin
			event_kind <= tpjd_pkg::EV_ASSIGNED;
			assigned_worker <= 3'(idx_head);
			out_tag <= head_tag;
			out_type_mask <= head_type;
			source_queue <= q_q;
			last_result <= 1'b0;
		end else if (cmd.rel) begin
			event_kind <= tpjd_pkg::EV_RELEASED;
			assigned_worker <= wid_q;
			out_tag <= '0;
			out_type_mask <= '0;
			source_queue <= tpjd_pkg::SRC_DIRECT;
			last_result <= 1'b1;
		end else if (cmd.fin) begin
			event_kind <= tpjd_pkg::EV_UPD_DONE;
			assigned_worker <= 3'd0;
			out_tag <= '0;
			out_type_mask <= '0;
			source_queue <= tpjd_pkg::SRC_DIRECT;
			last_result <= 1'b1;
		end
	end
endmodule
`default_nettype wire

[sv/typed_priority_job_dispatcher.sv]
// Top level: typed priority job dispatcher, controller plus datapath
// Submit and done: one result, registered from the submit or release state;
// the next request is taken at the edge that ends the result cycle.
// Update: read then check per assigned job, read (and check if not empty) per queue
// that stops, then the final result; the queues' registered read port sets the pace.
// Async active-low reset empties queues, frees workers, loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module typed_priority_job_dispatcher #(
	parameter int WORKERS      = tpjd_pkg::WORKERS_DEF,
	parameter int HIGH_DEPTH   = tpjd_pkg::HIGH_DEPTH_DEF,
	parameter int MEDIUM_DEPTH = tpjd_pkg::MEDIUM_DEPTH_DEF,
	parameter int LOW_DEPTH    = tpjd_pkg::LOW_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [1:0]                      func,
	input  wire logic [tpjd_pkg::TAG_BITS-1:0]   job_tag,
	input  wire logic [tpjd_pkg::TYPE_BITS-1:0]  job_type_mask,
	input  wire logic [1:0]                      priority_req,
	input  wire logic [2:0]                      worker_id,
	output logic                                 strobe,
	output logic [2:0]                           event_kind,
	output logic [2:0]                           assigned_worker,
	output logic [tpjd_pkg::TAG_BITS-1:0]        out_tag,
	output logic [tpjd_pkg::TYPE_BITS-1:0]       out_type_mask,
	output logic [1:0]                           source_queue,
	output logic                                 last_result,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [1:0]                      cfg_index,
	input  wire logic [tpjd_pkg::MASKS_BITS-1:0] cfg_data
);
	tpjd_pkg::cmd_t cmd;
	tpjd_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	tpjd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	tpjd_datapath #(
		.WORKERS      (WORKERS),
		.HIGH_DEPTH   (HIGH_DEPTH),
		.MEDIUM_DEPTH (MEDIUM_DEPTH),
		.LOW_DEPTH    (LOW_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.job_tag         (job_tag),
		.job_type_mask   (job_type_mask),
		.priority_req    (priority_req),
		.worker_id       (worker_id),
		.cmd             (cmd),
		.sts             (sts),
		.strobe          (strobe),
		.event_kind      (event_kind),
		.assigned_worker (assigned_worker),
		.out_tag         (out_tag),
		.out_type_mask   (out_type_mask),
		.source_queue    (source_queue),
		.last_result     (last_result)
	);
endmodule
`default_nettype wire

[sv/tpjd_checker.sv]
// Checker: port-level properties of the job dispatcher, bound to the top
`timescale 1ns / 1ps
`default_nettype none
`include "typed_priority_job_dispatcher_defines.svh"
module tpjd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [1:0] func,
	input wire logic       strobe,
	input wire logic [2:0] event_kind,
	input wire logic [1:0] source_queue,
	input wire logic       last_result
);
	`TPJD_ASSERT_D2(a_submit_answer, start && !busy && func == tpjd_pkg::FUNC_SUBMIT, strobe && last_result)
	`TPJD_ASSERT_D2(a_done_answer, start && !busy && func == tpjd_pkg::FUNC_DONE, strobe && event_kind == tpjd_pkg::EV_RELEASED)
	`TPJD_ASSERT_NOW(a_update_last, strobe && event_kind == tpjd_pkg::EV_UPD_DONE, last_result)
	`TPJD_ASSERT_NOW(a_queued_src, strobe && event_kind == tpjd_pkg::EV_QUEUED, source_queue != tpjd_pkg::SRC_DIRECT)
endmodule

bind typed_priority_job_dispatcher tpjd_checker u_tpjd_checker (.*);
`default_nettype wire

[sim/typed_priority_job_dispatcher_test.sv]
// Testbench for the typed priority job dispatcher: self-checking, directed and random requests
`timescale 1ns / 1ps
`default_nettype none
module typed_priority_job_dispatcher_test;
	localparam int IDLE_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TGB = tpjd_pkg::TAG_BITS;
	localparam int MKB = tpjd_pkg::MASKS_BITS;

	typedef struct packed {
		logic [2:0]     kind;
		logic [2:0]     wkr;
		logic [TGB-1:0] tag;
		logic [2:0]     tmask;
		logic [1:0]     src;
		logic           last;
	} dispatch_result_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        func;
	logic [TGB-1:0]    job_tag;
	logic [2:0]        job_type_mask;
	logic [1:0]        priority_req;
	logic [2:0]        worker_id;
	logic              strobe;
	logic [2:0]        event_kind;
	logic [2:0]        assigned_worker;
	logic [TGB-1:0]    out_tag;
	logic [2:0]        out_type_mask;
	logic [1:0]        source_queue;
	logic              last_result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [MKB-1:0]    cfg_data;

	typed_priority_job_dispatcher u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .job_tag(job_tag), .job_type_mask(job_type_mask),
		.priority_req(priority_req), .worker_id(worker_id),
		.strobe(strobe), .event_kind(event_kind), .assigned_worker(assigned_worker),
		.out_tag(out_tag), .out_type_mask(out_type_mask), .source_queue(source_queue),
		.last_result(last_result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// dispatcher shadow state
	logic            shadow_enable;
	logic [3:0]      shadow_count;
	logic [MKB-1:0]  shadow_masks;
	logic [7:0]      shadow_busy;
	logic [TGB-1:0]  queued_tag [1:3][0:511];
	logic [2:0]      queued_type [1:3][0:511];
	int              queue_head [1:3];
	int              queue_fill [1:3];

	dispatch_result_t scoreboard[$];
	int errors;
	int requests_sent;
	int results_seen;
	int idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int queue_depth(int q);
		if (q == 1)
			return tpjd_pkg::HIGH_DEPTH_DEF;
		else if (q == 2)
			return tpjd_pkg::MEDIUM_DEPTH_DEF;
		return tpjd_pkg::LOW_DEPTH_DEF;
	endfunction

	function automatic int find_idle_worker(logic [2:0] tmask);
		int n;
		n = (shadow_count > 8) ? 8 : int'(shadow_count);
		for (int w = 0; w < n; w++)
			if ((shadow_masks[w*3 +: 3] & tmask) != 3'd0 && !shadow_busy[w])
				return w;
		return -1;
	endfunction

	task automatic post_result(logic [2:0] kind, int w, logic [TGB-1:0] tag,
			logic [2:0] tmask, int src, logic last);
		dispatch_result_t r;
		r.kind = kind;
		r.wkr = w[2:0];
		r.tag = tag;
		r.tmask = tmask;
		r.src = src[1:0];
		r.last = last;
		scoreboard.push_back(r);
	endtask

	task automatic predict_request(tpjd_pkg::func_t f, logic [TGB-1:0] tag,
			logic [2:0] tmask, tpjd_pkg::prio_t p, logic [2:0] wid);
		int w;
		int q;
		int slot;
		bit stop;
		case (f)
			tpjd_pkg::FUNC_SUBMIT: begin
				q = (p == tpjd_pkg::PRIO_HIGH) ? 1 : (p == tpjd_pkg::PRIO_LOW) ? 3 : 2;
				w = (p == tpjd_pkg::PRIO_HIGH) ? find_idle_worker(tmask) : -1;
				if (w >= 0) begin
					shadow_busy[w] = 1'b1;
					post_result(tpjd_pkg::EV_ASSIGNED, w, tag, tmask, tpjd_pkg::SRC_DIRECT, 1'b1);
				end else if (queue_fill[q] >= queue_depth(q)) begin
					post_result(tpjd_pkg::EV_DROPPED, 0, tag, tmask, q, 1'b1);
				end else begin
					slot = (queue_head[q] + queue_fill[q]) % queue_depth(q);
					queued_tag[q][slot] = tag;
					queued_type[q][slot] = tmask;
					queue_fill[q]++;
					post_result(tpjd_pkg::EV_QUEUED, 0, tag, tmask, q, 1'b1);
				end
			end
			tpjd_pkg::FUNC_UPDATE: begin
				if (shadow_enable)
					for (q = 1; q <= 3; q++) begin
						stop = 1'b0;
						while (queue_fill[q] > 0 && !stop) begin
							w = find_idle_worker(queued_type[q][queue_head[q]]);
							if (w < 0) begin
								stop = 1'b1;
							end else begin
								shadow_busy[w] = 1'b1;
								post_result(tpjd_pkg::EV_ASSIGNED, w,
									queued_tag[q][queue_head[q]],
									queued_type[q][queue_head[q]], q, 1'b0);
								queue_head[q] = (queue_head[q] + 1) % queue_depth(q);
								queue_fill[q]--;
							end
						end
					end
				post_result(tpjd_pkg::EV_UPD_DONE, 0, '0, 3'd0, tpjd_pkg::SRC_DIRECT, 1'b1);
			end
			tpjd_pkg::FUNC_DONE: begin
				shadow_busy[wid] = 1'b0;
				post_result(tpjd_pkg::EV_RELEASED, int'(wid), '0, 3'd0,
					tpjd_pkg::SRC_DIRECT, 1'b1);
			end
			default: ;
		endcase
	endtask

	// called at a falling edge; returns at a falling edge with start still high
	task automatic send_request(tpjd_pkg::func_t f, logic [TGB-1:0] tag, logic [2:0] tmask,
			tpjd_pkg::prio_t p, logic [2:0] wid);
		int gap;
		gap = $urandom_range(0, 9);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		func = f;
		job_tag = tag;
		job_type_mask = tmask;
		priority_req = p;
		worker_id = wid;
		do @(posedge clk); while (busy);
		predict_request(f, tag, tmask, p, wid);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic submit_job(tpjd_pkg::prio_t p, logic [2:0] tmask);
		send_request(tpjd_pkg::FUNC_SUBMIT, TGB'($urandom), tmask, p, 3'($urandom));
	endtask

	task automatic run_update();
		send_request(tpjd_pkg::FUNC_UPDATE, TGB'($urandom), 3'($urandom),
			tpjd_pkg::prio_t'($urandom), 3'($urandom));
	endtask

	task automatic release_worker(logic [2:0] wid);
		send_request(tpjd_pkg::FUNC_DONE, TGB'($urandom), 3'($urandom),
			tpjd_pkg::prio_t'($urandom), wid);
	endtask

	// wait for every outstanding result, then let the block go idle
	task automatic settle();
		start = 1'b0;
		while (scoreboard.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(tpjd_pkg::reg_idx_t idx, logic [MKB-1:0] value);
		settle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tpjd_pkg::REG_ENABLE: shadow_enable = value[0];
			tpjd_pkg::REG_COUNT:  shadow_count = value[3:0];
			tpjd_pkg::REG_MASKS:  shadow_masks = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	always @(posedge clk) begin
		dispatch_result_t want;
		if (arst_n && strobe) begin
			results_seen++;
			if (scoreboard.size() == 0) begin
				$error("unexpected result: event_kind %0d out_tag %0h", event_kind, out_tag);
				errors++;
			end else begin
				want = scoreboard.pop_front();
				if (event_kind !== want.kind) begin
					$error("event_kind expected %0d actual %0d", want.kind, event_kind);
					errors++;
				end
				if (assigned_worker !== want.wkr) begin
					$error("assigned_worker expected %0d actual %0d", want.wkr, assigned_worker);
					errors++;
				end
				if (out_tag !== want.tag) begin
					$error("out_tag expected %0h actual %0h", want.tag, out_tag);
					errors++;
				end
				if (out_type_mask !== want.tmask) begin
					$error("out_type_mask expected %0d actual %0d", want.tmask, out_type_mask);
					errors++;
				end
				if (source_queue !== want.src) begin
					$error("source_queue expected %0d actual %0d", want.src, source_queue);
					errors++;
				end
				if (last_result !== want.last) begin
					$error("last_result expected %0d actual %0d", want.last, last_result);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic test_directed();
		send_request(tpjd_pkg::FUNC_SUBMIT, 16'hFFFF, 3'd7, tpjd_pkg::PRIO_HIGH, 3'd0);
		send_request(tpjd_pkg::FUNC_SUBMIT, 16'h0000, 3'd1, tpjd_pkg::PRIO_HIGH, 3'd7);
		send_request(tpjd_pkg::FUNC_SUBMIT, 16'hA5A5, 3'd2, tpjd_pkg::PRIO_MED, 3'd0);
		send_request(tpjd_pkg::FUNC_SUBMIT, 16'h5A5A, 3'd4, tpjd_pkg::PRIO_LOW, 3'd0);
		send_request(tpjd_pkg::FUNC_SUBMIT, 16'h1234, 3'd3, tpjd_pkg::PRIO_ALT, 3'd0);
		send_request(tpjd_pkg::FUNC_NONE, 16'hFFFF, 3'd7, tpjd_pkg::PRIO_ALT, 3'd7);
		run_update();
		release_worker(3'd7);
		release_worker(3'd0);
		release_worker(3'd1);
		release_worker(3'd7);
		run_update();
		for (int w = 0; w < 8; w++)
			release_worker(w[2:0]);
	endtask

	task automatic test_registers();
		write_reg(tpjd_pkg::REG_ENABLE, 24'd0);
		submit_job(tpjd_pkg::PRIO_MED, 3'd7);
		submit_job(tpjd_pkg::PRIO_HIGH, 3'd2);
		run_update();
		write_reg(tpjd_pkg::REG_ENABLE, 24'hFFFFFF);
		write_reg(tpjd_pkg::REG_COUNT, 24'd0);
		submit_job(tpjd_pkg::PRIO_HIGH, 3'd7);
		run_update();
		write_reg(tpjd_pkg::REG_MASKS, 24'd0);
		write_reg(tpjd_pkg::REG_COUNT, 24'hFFFFFF);
		submit_job(tpjd_pkg::PRIO_HIGH, 3'd7);
		run_update();
		write_reg(tpjd_pkg::REG_NONE, 24'hFFFFFF);
		write_reg(tpjd_pkg::REG_MASKS, 24'hFFFFFF);
		run_update();
		write_reg(tpjd_pkg::REG_COUNT, 24'd1);
		release_worker(3'd0);
		submit_job(tpjd_pkg::PRIO_HIGH, 3'd1);
		write_reg(tpjd_pkg::REG_COUNT, 24'd8);
		for (int w = 0; w < 8; w++)
			release_worker(w[2:0]);
		run_update();
	endtask

	task automatic test_random(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				submit_job(tpjd_pkg::prio_t'($urandom_range(0, 3)),
					3'($urandom_range(1, 7)));
			else if (r < 70)
				run_update();
			else if (r < 96)
				release_worker(3'($urandom));
			else
				send_request(tpjd_pkg::FUNC_NONE, TGB'($urandom), 3'($urandom),
					tpjd_pkg::prio_t'($urandom), 3'($urandom));
		end
	endtask

	// zero-mask jobs block their queues for good, so this runs last
	task automatic test_blocked_heads();
		write_reg(tpjd_pkg::REG_COUNT, 24'd0);
		submit_job(tpjd_pkg::PRIO_HIGH, 3'd0);
		submit_job(tpjd_pkg::PRIO_MED, 3'd0);
		submit_job(tpjd_pkg::PRIO_LOW, 3'd0);
		while (queue_fill[1] < queue_depth(1))
			submit_job(tpjd_pkg::PRIO_HIGH, 3'($urandom_range(0, 7)));
		submit_job(tpjd_pkg::PRIO_HIGH, 3'd7);
		write_reg(tpjd_pkg::REG_COUNT, 24'd8);
		for (int w = 0; w < 8; w++)
			release_worker(w[2:0]);
		run_update();
		submit_job(tpjd_pkg::PRIO_MED, 3'd6);
		run_update();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		func = tpjd_pkg::FUNC_SUBMIT;
		job_tag = '0;
		job_type_mask = '0;
		priority_req = tpjd_pkg::PRIO_LOW;
		worker_id = '0;
		cfg_valid = 1'b0;
		cfg_index = tpjd_pkg::REG_ENABLE;
		cfg_data = '0;
		errors = 0;
		requests_sent = 0;
		results_seen = 0;
		idle_cycles = 0;
		shadow_enable = 1'b1;
		shadow_count = 4'd8;
		shadow_masks = 24'hFFFFFF;
		shadow_busy = '0;
		for (int q = 1; q <= 3; q++) begin
			queue_head[q] = 0;
			queue_fill[q] = 0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_registers();
		write_reg(tpjd_pkg::REG_MASKS, 24'($urandom));
		test_random(50);
		write_reg(tpjd_pkg::REG_COUNT, 24'd3);
		write_reg(tpjd_pkg::REG_MASKS, 24'($urandom));
		test_random(35);
		write_reg(tpjd_pkg::REG_ENABLE, 24'd0);
		test_random(15);
		write_reg(tpjd_pkg::REG_ENABLE, 24'd1);
		write_reg(tpjd_pkg::REG_COUNT, 24'd15);
		write_reg(tpjd_pkg::REG_MASKS, 24'hFFFFFF);
		test_random(50);
		test_blocked_heads();

		settle();
		repeat (20) @(posedge clk);
		$display("Covered %0d requests and %0d results: submits, updates, releases,",
			requests_sent, results_seen);
		$display("a full high queue, blocked heads, dispatch off and worker counts 0 to 15.");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
+incdir+sv
sv/tpjd_pkg.sv
sv/tpjd_ctrl.sv
sv/tpjd_datapath.sv
sv/typed_priority_job_dispatcher.sv
sv/tpjd_checker.sv
sim/typed_priority_job_dispatcher_test.sv
